@@ hdl/pwfr_pkg.sv @@
// Shared types and constants for the pulse width frame receiver.
`timescale 1ns / 1ps

package pwfr_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] REG_WINDOW_LEN   = 3'd0;
   localparam logic [2:0] REG_HIGH_POS     = 3'd1;
   localparam logic [2:0] REG_LOW_POS      = 3'd2;
   localparam logic [2:0] REG_NULL_POS     = 3'd3;
   localparam logic [2:0] REG_TOLERANCE    = 3'd4;
   localparam logic [2:0] REG_PREAMBLE_LEN = 3'd5;
   localparam logic [2:0] REG_EXPECTED     = 3'd6;
   localparam logic [2:0] REG_HOLDOFF      = 3'd7;

   // Register reset values
   localparam logic [7:0] RST_WINDOW_LEN   = 8'd20;
   localparam logic [7:0] RST_HIGH_POS     = 8'd5;
   localparam logic [7:0] RST_LOW_POS      = 8'd15;
   localparam logic [7:0] RST_NULL_POS     = 8'd10;
   localparam logic [7:0] RST_TOLERANCE    = 8'd2;
   localparam logic [7:0] RST_PREAMBLE_LEN = 8'd3;
   localparam logic [7:0] RST_EXPECTED     = 8'h34;
   localparam logic [7:0] RST_HOLDOFF      = 8'd20;

   // Frame status codes
   localparam logic [1:0] ST_MATCH    = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_FAIL     = 2'd2;
   localparam logic [1:0] ST_UNUSED   = 2'd3;

   // Symbol classes of a finished window
   typedef enum logic [1:0] {
      SYM_HIGH = 2'd0,
      SYM_LOW  = 2'd1,
      SYM_NULL = 2'd2,
      SYM_BAD  = 2'd3
   } sym_type;

   // True when pos lies within centre +/- tol, without wrap
   function automatic logic near_pos(input logic [7:0] pos, input logic [7:0] centre,
                                     input logic [7:0] tol);
      logic [8:0] pos_up;
      logic [8:0] centre_up;
      pos_up    = {1'b0, pos} + {1'b0, tol};
      centre_up = {1'b0, centre} + {1'b0, tol};
      return (pos_up >= {1'b0, centre}) && ({1'b0, pos} <= centre_up);
   endfunction

endpackage

@@ hdl/pulse_width_frame_receiver.sv @@
// Pulse width frame receiver: edge sync, windowed fall capture, symbol decode, frame result.
// A result appears on rsp_ in the cycle after the request that closes the frame.
// Throughput: one sample request per cycle; req_tready drops only while a result waits
// in the single output register and rsp_tready is low.
// All per-sample work is one pass of compares and counters ahead of that register.
// Reset: synchronous, active high; all but result data take defaults, phase is sync.
`timescale 1ns / 1ps

module pulse_width_frame_receiver
   import pwfr_pkg::*;
#(
   parameter int DATA_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] sample_level, [7:1] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] frame_status, [9:2] received_byte, [15:10] zero
   // configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   localparam int CNT_W = $clog2(DATA_BITS + 1);

   typedef enum logic [1:0] {
      PH_SYNC = 2'd0,
      PH_NULL = 2'd1,
      PH_DATA = 2'd2,
      PH_HOLD = 2'd3
   } phase_type;

   // Configuration registers
   logic [7:0] window_len_ff, high_pos_ff, low_pos_ff, null_pos_ff;
   logic [7:0] tolerance_ff, preamble_len_ff, expected_ff, holdoff_ff;

   // Receiver state
   phase_type        phase_ff, phase_in;
   logic             prev_level_ff, prev_level_in;
   logic [7:0]       sample_index_ff, sample_index_in;
   logic [7:0]       fall_pos_ff, fall_pos_in;
   logic [7:0]       null_run_ff, null_run_in;
   logic [CNT_W-1:0] bit_count_ff, bit_count_in;
   logic [7:0]       shift_data_ff, shift_data_in;
   logic [7:0]       holdoff_count_ff, holdoff_count_in;

   // Result register
   logic       rsp_tvalid_ff;
   logic [1:0] status_ff;
   logic [7:0] byte_ff;

   logic       req_accept;
   logic       level;
   logic       emit;
   logic [1:0] emit_status;
   logic [7:0] pos;
   sym_type    sym;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign level      = req_tdata[0];

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, byte_ff, status_ff};

   // Fall position of the current window, counting a fall at this request
   assign pos = (sample_index_ff != 8'd0 && fall_pos_ff == 8'd0 && prev_level_ff && !level) ?
                sample_index_ff : fall_pos_ff;

   // Classify the fall position of the window that closes with this request
   always_comb begin
      if (pos == 8'd0) begin
         sym = SYM_BAD;
      end else if (near_pos(pos, high_pos_ff, tolerance_ff)) begin
         sym = SYM_HIGH;
      end else if (near_pos(pos, low_pos_ff, tolerance_ff)) begin
         sym = SYM_LOW;
      end else if (near_pos(pos, null_pos_ff, tolerance_ff)) begin
         sym = SYM_NULL;
      end else begin
         sym = SYM_BAD;
      end
   end

   // Next state for one accepted sample
   always_comb begin
      phase_in         = phase_ff;
      prev_level_in    = prev_level_ff;
      sample_index_in  = sample_index_ff;
      fall_pos_in      = fall_pos_ff;
      null_run_in      = null_run_ff;
      bit_count_in     = bit_count_ff;
      shift_data_in    = shift_data_ff;
      holdoff_count_in = holdoff_count_ff;
      emit             = 1'b0;
      emit_status      = ST_FAIL;

      if (phase_ff == PH_SYNC) begin
         // wait for a rising edge
         if (!prev_level_ff && level) begin
            sample_index_in = 8'd0;
            fall_pos_in     = 8'd0;
            null_run_in     = 8'd0;
            bit_count_in    = '0;
            shift_data_in   = 8'd0;
            phase_in        = (preamble_len_ff == 8'd0) ? PH_DATA : PH_NULL;
         end
         prev_level_in = level;
      end else begin
         // capture the first fall inside the window
         if (sample_index_ff != 8'd0 && fall_pos_ff == 8'd0 && prev_level_ff && !level) begin
            fall_pos_in = sample_index_ff;
         end
         prev_level_in = level;

         if (({1'b0, sample_index_ff} + 9'd1) < {1'b0, window_len_ff}) begin
            sample_index_in = sample_index_ff + 8'd1;
         end else begin
            // window complete
            sample_index_in = 8'd0;
            fall_pos_in     = 8'd0;
            unique case (phase_ff)
               PH_HOLD: begin
                  if (holdoff_count_ff != 8'hFF) begin
                     holdoff_count_in = holdoff_count_ff + 8'd1;
                  end
                  if (holdoff_count_in >= holdoff_ff) begin
                     phase_in      = PH_SYNC;
                     prev_level_in = 1'b1;
                  end
               end
               PH_NULL: begin
                  if (sym == SYM_NULL) begin
                     if (null_run_ff != 8'hFF) begin
                        null_run_in = null_run_ff + 8'd1;
                     end
                  end else begin
                     null_run_in = 8'd0;
                  end
                  if (null_run_in >= preamble_len_ff) begin
                     phase_in      = PH_DATA;
                     bit_count_in  = '0;
                     shift_data_in = 8'd0;
                  end
               end
               PH_DATA: begin
                  if (sym == SYM_HIGH || sym == SYM_LOW) begin
                     if (sym == SYM_HIGH) begin
                        shift_data_in = shift_data_ff | (8'd1 << bit_count_ff);
                     end
                     bit_count_in = bit_count_ff + CNT_W'(1);
                     if (bit_count_in >= CNT_W'(DATA_BITS)) begin
                        emit        = 1'b1;
                        emit_status = (shift_data_in == expected_ff) ? ST_MATCH : ST_MISMATCH;
                     end
                  end else if (!(sym == SYM_NULL && bit_count_ff == '0)) begin
                     emit        = 1'b1;
                     emit_status = ST_FAIL;
                  end
                  // frame end: hold off or resync
                  if (emit) begin
                     if (holdoff_ff == 8'd0) begin
                        phase_in      = PH_SYNC;
                        prev_level_in = 1'b1;
                     end else begin
                        phase_in         = PH_HOLD;
                        holdoff_count_in = 8'd0;
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff   <= RST_WINDOW_LEN;
         high_pos_ff     <= RST_HIGH_POS;
         low_pos_ff      <= RST_LOW_POS;
         null_pos_ff     <= RST_NULL_POS;
         tolerance_ff    <= RST_TOLERANCE;
         preamble_len_ff <= RST_PREAMBLE_LEN;
         expected_ff     <= RST_EXPECTED;
         holdoff_ff      <= RST_HOLDOFF;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_WINDOW_LEN:   window_len_ff   <= csr_wdata;
            REG_HIGH_POS:     high_pos_ff     <= csr_wdata;
            REG_LOW_POS:      low_pos_ff      <= csr_wdata;
            REG_NULL_POS:     null_pos_ff     <= csr_wdata;
            REG_TOLERANCE:    tolerance_ff    <= csr_wdata;
            REG_PREAMBLE_LEN: preamble_len_ff <= csr_wdata;
            REG_EXPECTED:     expected_ff     <= csr_wdata;
            REG_HOLDOFF:      holdoff_ff      <= csr_wdata;
            default:          window_len_ff   <= window_len_ff;
         endcase
      end
   end

   // Advance receiver state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SYNC;
         prev_level_ff    <= 1'b1;
         sample_index_ff  <= 8'd0;
         fall_pos_ff      <= 8'd0;
         null_run_ff      <= 8'd0;
         bit_count_ff     <= '0;
         shift_data_ff    <= 8'd0;
         holdoff_count_ff <= 8'd0;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         prev_level_ff    <= prev_level_in;
         sample_index_ff  <= sample_index_in;
         fall_pos_ff      <= fall_pos_in;
         null_run_ff      <= null_run_in;
         bit_count_ff     <= bit_count_in;
         shift_data_ff    <= shift_data_in;
         holdoff_count_ff <= holdoff_count_in;
      end
   end

   // Load the result register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_accept && emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         status_ff <= emit_status;
         byte_ff   <= shift_data_in;
      end
   end

`ifndef SYNTHESIS
   // A frame result from the sync phase would be spurious
   a_no_result_in_sync: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SYNC) |-> !emit)
      else $error("result raised during sync");

   // The bit counter never runs past the frame length
   a_bit_count_bound: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= CNT_W'(DATA_BITS))
      else $error("bit count beyond frame length");

   // An accepted closing request always shows up on the result side
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit) |=> rsp_tvalid_ff)
      else $error("frame result lost");

   // A held result never carries the unused status code
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (status_ff != ST_UNUSED))
      else $error("illegal frame status");

   // After a frame the receiver is in hold-off or back in sync
   a_frame_end_phase: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit) |=> (phase_ff == PH_HOLD || phase_ff == PH_SYNC))
      else $error("frame end left receiver in a frame phase");
`endif

endmodule
